// ===== hw/rtl/circular_ticket_queue_unit_assert.svh =====
// Assertion macros for the ticket queue RTL.
`ifndef CIRCULAR_TICKET_QUEUE_UNIT_ASSERT_SVH
`define CIRCULAR_TICKET_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ctq_pkg.sv =====
package ctq_pkg;

   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_TICKET_WIDTH = 32;

   // Operation codes; codes five to seven do nothing.
   localparam logic [2:0] OP_ENQUEUE = 3'd0;
   localparam logic [2:0] OP_SERVE   = 3'd1;
   localparam logic [2:0] OP_REMOVE  = 3'd2;
   localparam logic [2:0] OP_PEEK    = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [1:0] STATUS_BADPOS = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] ticket_in;
      logic [3:0]  position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] ticket_out;
      logic [4:0]  queue_length;
   } rsp_type;

endpackage

// ===== hw/rtl/ctq_ram.sv =====
module ctq_ram
   import ctq_pkg::*;
#(
   parameter int Depth = DEF_QUEUE_DEPTH,
   parameter int Width = DEF_TICKET_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] store_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // A read of the entry written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ctq_ctrl.sv =====
module ctq_ctrl
   import ctq_pkg::*;
#(
   parameter int QueueDepth  = DEF_QUEUE_DEPTH,
   parameter int TicketWidth = DEF_TICKET_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  req_type                       req_data,
   output logic                          idle,
   output logic                          res_valid,
   output rsp_type                       res_data,
   input  logic                          res_take,
   output logic                          mem_wr_en,
   output logic [$clog2(QueueDepth)-1:0] mem_wr_addr,
   output logic [TicketWidth-1:0]        mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(QueueDepth)-1:0] mem_rd_addr,
   input  logic [TicketWidth-1:0]        mem_rd_data
);

   localparam int IdxW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam int CmpW = (CntW > 4) ? CntW : 4;
   localparam int SumW = CmpW + 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdxW-1:0] slot_ff, slot_in;
   logic [IdxW-1:0] src_ff, src_in;
   logic [CntW-1:0] moves_ff, moves_in;
   rsp_type         res_ff, res_in;

   logic            full;
   logic            empty;
   logic [CmpW-1:0] count_wide;
   logic [CmpW-1:0] pos_wide;
   logic            pos_ok;
   logic [SumW-1:0] pos_sum;
   logic [SumW-1:0] pos_wrap;
   logic [IdxW-1:0] rm_slot;
   logic [CntW-1:0] rm_moves;

   function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
      return (i == IdxW'(QueueDepth - 1)) ? '0 : i + IdxW'(1);
   endfunction

   function automatic logic [IdxW-1:0] prev_idx(input logic [IdxW-1:0] i);
      return (i == '0) ? IdxW'(QueueDepth - 1) : i - IdxW'(1);
   endfunction

   assign full       = (count_ff == CntW'(QueueDepth));
   assign empty      = (count_ff == '0);
   assign count_wide = CmpW'(count_ff);
   assign pos_wide   = CmpW'(req_data.position);
   assign pos_ok     = (pos_wide < count_wide);

   // Slot of the removed entry: head plus position stays below twice the depth.
   assign pos_sum  = SumW'(head_ff) + SumW'(req_data.position);
   assign pos_wrap = (pos_sum >= SumW'(QueueDepth)) ? pos_sum - SumW'(QueueDepth) : pos_sum;
   assign rm_slot  = IdxW'(pos_wrap);
   assign rm_moves = CntW'(count_wide - pos_wide - CmpW'(1));

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      slot_in     = slot_ff;
      src_in      = src_ff;
      moves_in    = moves_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = next_idx(tail_ff);
      mem_wr_data = TicketWidth'(req_data.ticket_in);
      mem_rd_en   = 1'b0;
      mem_rd_addr = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in.status     = STATUS_OK;
               res_in.ticket_out = '0;
               state_in          = S_DONE;
               unique case (req_data.opcode)
                  OP_ENQUEUE: begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        tail_in   = next_idx(tail_ff);
                        count_in  = count_ff + CntW'(1);
                     end
                  end
                  OP_SERVE: begin
                     if (empty) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_ff;
                        head_in     = next_idx(head_ff);
                        count_in    = count_ff - CntW'(1);
                        state_in    = S_READ;
                     end
                  end
                  OP_REMOVE: begin
                     if (!pos_ok) begin
                        res_in.status = STATUS_BADPOS;
                     end else begin
                        tail_in  = prev_idx(tail_ff);
                        count_in = count_ff - CntW'(1);
                        if (rm_moves != '0) begin
                           mem_rd_en   = 1'b1;
                           mem_rd_addr = next_idx(rm_slot);
                           slot_in     = rm_slot;
                           src_in      = next_idx(rm_slot);
                           moves_in    = rm_moves;
                           state_in    = S_SHIFT;
                        end
                     end
                  end
                  OP_PEEK: begin
                     if (empty) begin
                        res_in.status = STATUS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = tail_ff;
                        state_in    = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     head_in  = '0;
                     tail_in  = IdxW'(QueueDepth - 1);
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               res_in.queue_length = 5'(count_in);
            end
         end
         S_READ: begin
            res_in.ticket_out = 32'(mem_rd_data);
            state_in          = S_DONE;
         end
         S_SHIFT: begin
            // Entry read last cycle moves one slot toward the head.
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_ff;
            mem_wr_data = mem_rd_data;
            slot_in     = src_ff;
            src_in      = next_idx(src_ff);
            moves_in    = moves_ff - CntW'(1);
            if (moves_ff == CntW'(1)) begin
               state_in = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = next_idx(src_ff);
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= IdxW'(QueueDepth - 1);
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      src_ff   <= src_in;
      moves_ff <= moves_in;
      res_ff   <= res_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

endmodule

// ===== hw/rtl/circular_ticket_queue_unit.sv =====
// Channel   Direction  Ports                             Payload
// request   in         req_valid, req_stall, req_data    req_type (opcode, ticket, position)
// response  out        rsp_valid, rsp_stall, rsp_data    rsp_type (status, ticket, length)
//
// Items are handled one at a time. Enqueue, clear, refusals and unused codes go
// straight to the done state; serve and peek first pass a read state for the
// synchronous ticket memory read, and a removal shifts each later entry, one per step.
// Reset is synchronous and active high; it empties the queue but leaves the
// ticket memory as it is. A stalled response waits in the output register while
// the next item is already accepted and worked on.
`include "circular_ticket_queue_unit_assert.svh"

module circular_ticket_queue_unit
   import ctq_pkg::*;
#(
   parameter int QueueDepth  = DEF_QUEUE_DEPTH,
   parameter int TicketWidth = DEF_TICKET_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IdxW = $clog2(QueueDepth);

   logic                   ctrl_idle;
   logic                   res_valid;
   rsp_type                res_data;
   logic                   res_take;
   logic                   mem_wr_en;
   logic [IdxW-1:0]        mem_wr_addr;
   logic [TicketWidth-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [IdxW-1:0]        mem_rd_addr;
   logic [TicketWidth-1:0] mem_rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // The sequencer owns the head, tail and count and drives the memory port.
   ctq_ctrl #(
      .QueueDepth  (QueueDepth),
      .TicketWidth (TicketWidth)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .idle        (ctrl_idle),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_take    (res_take),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Ticket storage: one write and one registered read per cycle.
   ctq_ram #(
      .Depth (QueueDepth),
      .Width (TicketWidth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // A new item is taken only when the sequencer is free.
   assign req_stall = !ctrl_idle;

   // The output register loads a finished result whenever it is empty or draining.
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted item keeps the sequencer busy for at least the next cycle.
   `CTQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall,
                    "accepted item did not occupy the sequencer")
   // A finished result meeting an empty output register must be presented next cycle.
   `CTQ_ASSERT_NEXT(a_result_loaded, clock, reset, res_valid && !rsp_valid_ff, rsp_valid,
                    "finished result was not loaded into the output register")
   // A refused enqueue reports a full queue.
   `CTQ_ASSERT_SAME(a_full_length, clock, reset,
                    rsp_valid && (rsp_data.status == STATUS_FULL),
                    rsp_data.queue_length == 5'(QueueDepth),
                    "full status with a length other than the depth")
   // An empty report carries no ticket and a zero length.
   `CTQ_ASSERT_SAME(a_empty_result, clock, reset,
                    rsp_valid && (rsp_data.status == STATUS_EMPTY),
                    (rsp_data.queue_length == '0) && (rsp_data.ticket_out == '0),
                    "empty status with a ticket or a non-zero length")

endmodule

// ===== tb/circular_ticket_queue_unit_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the circular ticket queue. Each accepted request item
// is run through a behavioural copy of the ring buffer held here in the bench.
// The copy yields the response that the block must return. Responses arrive in
// order, one per request, and are compared field by field with the oldest
// outstanding prediction.
module circular_ticket_queue_unit_tb;
   import ctq_pkg::*;

   localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
   // Codes five to seven are unused and must behave as a no-operation.
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic [31:0] TICKET_ONES = 32'hFFFF_FFFF;
   // The slowest correct run costs per item the longest sender gap, the
   // longest removal and the longest response stall together. The limit
   // below is several times that over the whole run.
   localparam int CYCLE_LIMIT = 500000;
   localparam int END_SETTLE  = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   circular_ticket_queue_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the queue. Slots are only read between head and tail, so
   // slots that were never written are never looked at.
   logic [31:0] shadow_slots [QUEUE_DEPTH];
   int shadow_head  = 0;
   int shadow_tail  = QUEUE_DEPTH - 1;
   int shadow_count = 0;

   // Responses predicted for accepted items, oldest first.
   rsp_type predicted_responses [$];
   rsp_type oldest_prediction;

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  stall_left  = 0;
   // Set for one cycle after each accepted response.
   bit  rsp_taken   = 1'b0;
   // When set, neither side idles; this gives stretches at full rate.
   bit  full_rate   = 1'b0;

   // Applies one operation to the shadow queue and returns the response that
   // the block should give for it.
   function automatic rsp_type apply_ticket_op(req_type item);
      rsp_type resp;
      int      slot;
      int      moves;
      resp.status     = STATUS_OK;
      resp.ticket_out = '0;
      case (item.opcode)
         OP_ENQUEUE: begin
            if (shadow_count < QUEUE_DEPTH) begin
               shadow_tail = (shadow_tail + 1) % QUEUE_DEPTH;
               shadow_slots[shadow_tail] = item.ticket_in;
               shadow_count++;
            end else begin
               resp.status = STATUS_FULL;
            end
         end
         OP_SERVE: begin
            if (shadow_count != 0) begin
               resp.ticket_out = shadow_slots[shadow_head];
               shadow_head = (shadow_head + 1) % QUEUE_DEPTH;
               shadow_count--;
            end else begin
               resp.status = STATUS_EMPTY;
            end
         end
         OP_REMOVE: begin
            // The position counts from the head; every later entry moves one
            // slot towards the head and the tail steps back by one.
            if (int'(item.position) < shadow_count) begin
               slot  = (shadow_head + int'(item.position)) % QUEUE_DEPTH;
               moves = shadow_count - 1 - int'(item.position);
               for (int k = 0; k < moves; k++) begin
                  shadow_slots[slot] = shadow_slots[(slot + 1) % QUEUE_DEPTH];
                  slot = (slot + 1) % QUEUE_DEPTH;
               end
               shadow_tail = (shadow_tail + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               shadow_count--;
            end else begin
               resp.status = STATUS_BADPOS;
            end
         end
         OP_PEEK: begin
            if (shadow_count != 0) begin
               resp.ticket_out = shadow_slots[shadow_tail];
            end else begin
               resp.status = STATUS_EMPTY;
            end
         end
         OP_CLEAR: begin
            shadow_head  = 0;
            shadow_tail  = QUEUE_DEPTH - 1;
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      resp.queue_length = 5'(shadow_count);
      return resp;
   endfunction

   function automatic req_type make_item(logic [2:0] opcode, logic [31:0] ticket,
                                         logic [3:0] position);
      req_type item;
      item.opcode    = opcode;
      item.ticket_in = ticket;
      item.position  = position;
      return item;
   endfunction

   // Ticket codes lean towards the all-zero and all-one extremes now and then.
   function automatic logic [31:0] random_ticket();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return TICKET_ONES;
      end
      return $urandom;
   endfunction

   // Presents one item after a random gap and holds it until it is accepted.
   // Every call starts at a falling edge, where valid is either lowered or
   // given the next item, so an item is never presented twice.
   task automatic send_item(req_type item);
      int gap;
      gap = full_rate ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_responses.push_back(apply_ticket_op(item));
   endtask

   // Stops sending and waits until every predicted response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_responses.size() != 0) @(posedge clock);
   endtask

   // Builds a random operation. enqueue_pct sets how often a ticket is added,
   // which steers the length towards full or towards empty. Positions mostly
   // fall inside the queue so that removals really shift entries.
   task automatic send_random_op(int enqueue_pct);
      req_type item;
      int      pick;
      item.ticket_in = random_ticket();
      if (shadow_count > 0 && $urandom_range(0, 99) < 80) begin
         item.position = 4'($urandom_range(0, shadow_count - 1));
      end else begin
         item.position = 4'($urandom_range(0, 15));
      end
      pick = $urandom_range(0, 999);
      if (pick < 8) begin
         item.opcode = OP_CLEAR;
      end else if (pick < 25) begin
         item.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if ($urandom_range(0, 99) < enqueue_pct) begin
         item.opcode = OP_ENQUEUE;
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            item.opcode = OP_SERVE;
         end else if (pick < 8) begin
            item.opcode = OP_REMOVE;
         end else begin
            item.opcode = OP_PEEK;
         end
      end
      send_item(item);
   endtask

   // The extremes of every field, every operation and the empty and bad-position refusals.
   task automatic test_edge_cases();
      send_item(make_item(OP_SERVE, 32'h0, 4'd0));            // serve when empty
      send_item(make_item(OP_PEEK, TICKET_ONES, 4'd0));       // peek when empty
      send_item(make_item(OP_REMOVE, 32'h0, 4'd0));           // remove from empty
      send_item(make_item(OP_REMOVE, 32'h0, 4'd15));
      send_item(make_item(OP_ENQUEUE, 32'h0, 4'd15));
      send_item(make_item(OP_ENQUEUE, TICKET_ONES, 4'd0));
      send_item(make_item(OP_ENQUEUE, 32'hA5A5_5A5A, 4'd0));
      send_item(make_item(OP_PEEK, 32'h0, 4'd0));
      send_item(make_item(OP_REMOVE, 32'h0, 4'd2));           // tail, nothing shifts
      send_item(make_item(OP_REMOVE, 32'h0, 4'd2));           // position equals length
      send_item(make_item(OP_ENQUEUE, 32'h5A5A_A5A5, 4'd0));
      send_item(make_item(OP_REMOVE, 32'h0, 4'd0));           // head, the rest shifts
      send_item(make_item(OP_SERVE, 32'h0, 4'd0));
      send_item(make_item(OP_SERVE, 32'h0, 4'd0));
      send_item(make_item(OP_SERVE, 32'h0, 4'd0));            // empty again
      send_item(make_item(OP_ENQUEUE, 32'h1234_5678, 4'd0));
      for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
         send_item(make_item(3'(code), TICKET_ONES, 4'd15));
      end
      send_item(make_item(OP_CLEAR, 32'h0, 4'd0));
      send_item(make_item(OP_PEEK, 32'h0, 4'd0));             // nothing readable after clear
      send_item(make_item(OP_ENQUEUE, 32'h8000_0001, 4'd0));
      send_item(make_item(OP_SERVE, 32'h0, 4'd0));
   endtask

   // Fills the queue to the brim, tries one enqueue too many, then takes it
   // apart by removals, first at the far extremes and then at random positions.
   task automatic test_fill_and_drain(int rounds);
      for (int r = 0; r < rounds; r++) begin
         while (shadow_count < QUEUE_DEPTH) begin
            send_item(make_item(OP_ENQUEUE, random_ticket(), 4'($urandom)));
         end
         send_item(make_item(OP_ENQUEUE, random_ticket(), 4'd0));   // queue full
         send_item(make_item(OP_PEEK, 32'h0, 4'd0));
         send_item(make_item(OP_REMOVE, 32'h0, 4'd0));            // longest shift
         send_item(make_item(OP_ENQUEUE, random_ticket(), 4'd0));
         send_item(make_item(OP_REMOVE, 32'h0, 4'd15));           // tail of a full queue
         while (shadow_count > 0) begin
            send_item(make_item(OP_REMOVE, 32'h0, 4'($urandom_range(0, shadow_count - 1))));
         end
         send_item(make_item(OP_REMOVE, 32'h0, 4'($urandom)));
         // Leave the head somewhere other than slot zero for the next round.
         send_item(make_item(OP_ENQUEUE, random_ticket(), 4'd0));
         send_item(make_item(OP_SERVE, 32'h0, 4'd0));
      end
   endtask

   // Long random traffic in phases that push the length up and then down,
   // so that the ring wraps many times at every fill level.
   task automatic test_random_traffic(int phases, int items_per_phase);
      int enqueue_pct;
      for (int p = 0; p < phases; p++) begin
         case (p % 3)
            0:       enqueue_pct = 75;
            1:       enqueue_pct = 30;
            default: enqueue_pct = 50;
         endcase
         repeat (items_per_phase) send_random_op(enqueue_pct);
         // Now and then the sender holds off until the block has caught up.
         if (p % 4 == 3) begin
            wait_for_drain();
         end
      end
   endtask

   // Back-to-back items with the result side drawing no new stalls.
   task automatic test_full_rate_burst(int items);
      full_rate = 1'b1;
      repeat (items) send_random_op(55);
      full_rate = 1'b0;
   endtask

   // The result side draws a fresh stall length after every accepted result,
   // so its stalls land on every phase of the block's work.
   always @(negedge clock) begin : stall_draw
      int wait_cycles;
      wait_cycles = stall_left;
      if (rsp_taken) begin
         wait_cycles = full_rate ? 0 : $urandom_range(0, 13);
      end
      if (wait_cycles > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= wait_cycles - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end
   end

   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_responses.size() == 0) begin
            $display("%0t: response %h arrived with no item outstanding", $time, rsp_data);
            fail_count++;
         end else begin
            oldest_prediction = predicted_responses.pop_front();
            if (rsp_data.status !== oldest_prediction.status) begin
               $display("%0t: status expected %0d, got %0d", $time,
                        oldest_prediction.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.ticket_out !== oldest_prediction.ticket_out) begin
               $display("%0t: ticket expected %h, got %h", $time,
                        oldest_prediction.ticket_out, rsp_data.ticket_out);
               fail_count++;
            end
            if (rsp_data.queue_length !== oldest_prediction.queue_length) begin
               $display("%0t: length expected %0d, got %0d", $time,
                        oldest_prediction.queue_length, rsp_data.queue_length);
               fail_count++;
            end
         end
      end
   end

   // Guards against a hang anywhere in the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_fill_and_drain(3);
      wait_for_drain();
      test_random_traffic(14, 100);
      test_full_rate_burst(120);

      // Everything sent; wait for the last responses, then a little longer
      // so that any stray response would still be caught.
      wait_for_drain();
      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0 && predicted_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== circular_ticket_queue_unit.f =====
+incdir+hw/rtl
hw/rtl/ctq_pkg.sv
hw/rtl/ctq_ram.sv
hw/rtl/ctq_ctrl.sv
hw/rtl/circular_ticket_queue_unit.sv
tb/circular_ticket_queue_unit_tb.sv
